@@ rtl/avnt_pkg.sv @@
package avnt_pkg;

    // Field and datapath widths.
    localparam int QW         = 20;  // one Q8.12 component
    localparam int RW         = 60;  // one packed column register
    localparam int PW         = 40;  // product of two components
    localparam int LW         = 40;  // squared column length
    localparam int NW         = 53;  // rounded dividend
    localparam int QTW        = 33;  // quotient bits produced by the divider
    localparam int SW         = 43;  // position sum before rounding
    localparam int DIV_STEPS  = 3;   // quotient bits per divider stage
    localparam int DIV_STAGES = QTW / DIV_STEPS;

    // Configuration register indexes.
    localparam logic [7:0] REG_COL_X = 8'd0;
    localparam logic [7:0] REG_COL_Y = 8'd1;
    localparam logic [7:0] REG_COL_Z = 8'd2;
    localparam logic [7:0] REG_TRANS = 8'd3;

    localparam logic FUNC_POSITION  = 1'b0;
    localparam logic FUNC_DIRECTION = 1'b1;

    // Control and side data that travels beside the divider lanes.
    typedef struct packed {
        logic                 vld;
        logic                 func;
        logic                 last;
        logic [2:0][SW-1:0]   pos;
        logic [8:0]           neg;
        logic [2:0]           zero;
    } t_side;

    // Three restoring division steps on a {remainder, quotient} pair.
    function automatic logic [LW+QTW-1:0] div_step3(input logic [LW-1:0]  a_in,
                                                   input logic [QTW-1:0] q_in,
                                                   input logic [LW-1:0]  den);
        logic [LW-1:0]  a;
        logic [QTW-1:0] q;
        logic [LW:0]    t;
        a = a_in;
        q = q_in;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {a, q[QTW-1]};
            q = {q[QTW-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                q[0] = 1'b1;
            end
            a = t[LW-1:0];
        end
        return {a, q};
    endfunction

endpackage

@@ rtl/avnt_div_pipe.sv @@
module avnt_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [avnt_pkg::NW-1:0]    i_num,
    input  logic [avnt_pkg::LW-1:0]    i_den,
    output logic [avnt_pkg::QTW-1:0]   o_quot
);
    import avnt_pkg::*;

    logic [LW-1:0]  r_a [DIV_STAGES];
    logic [QTW-1:0] r_q [DIV_STAGES];

    // One stage per three quotient bits; the upper dividend bits seed the remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_a[0], r_q[0]} <= div_step3(LW'(i_num[NW-1:QTW]), i_num[QTW-1:0], i_den);
            for (int s = 1; s < DIV_STAGES; s++) begin
                {r_a[s], r_q[s]} <= div_step3(r_a[s-1], r_q[s-1], i_den);
            end
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

@@ rtl/affine_vertex_normal_transform.sv @@
// Throughput: one item per cycle; the 11-stage divider (3 quotient bits per stage)
// and the product and sum stages all advance together whenever the output is free.
// Reset: synchronous active low; clears all valid bits and loads the identity matrix
// with zero translation. No clearing pass is needed.
module affine_vertex_normal_transform (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_func,
    input  logic signed [19:0]        i_in_x,
    input  logic signed [19:0]        i_in_y,
    input  logic signed [19:0]        i_in_z,
    input  logic                      i_in_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [19:0]        o_out_x,
    output logic signed [19:0]        o_out_y,
    output logic signed [19:0]        o_out_z,
    output logic                      o_flag,
    output logic                      o_out_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [7:0]                i_cfg_index,
    input  logic [avnt_pkg::RW-1:0]   i_cfg_data
);
    import avnt_pkg::*;

    logic                  en;
    logic [RW-1:0]         r_col [3];
    logic [RW-1:0]         r_trans;
    logic [2*QW-2:0]       r_sq [3][3];
    logic [LW-1:0]         r_len [3];

    logic                  r_v0, r_v1, r_v2;
    logic                  r_f0, r_f1, r_f2;
    logic                  r_l0, r_l1, r_l2;
    logic signed [QW-1:0]  r_in [3];
    logic signed [PW-1:0]  r_p [3][3];
    logic [2:0][SW-1:0]    r_pos;
    logic [8:0]            r_neg;
    logic [NW-1:0]         r_num [9];
    t_side                 r_side [DIV_STAGES];
    t_side                 s2_side;
    logic [QTW-1:0]        quot [9];

    logic                  r_out_vld;
    logic signed [QW-1:0]  r_out [3];
    logic                  r_flag;
    logic                  r_last;

    assign en          = ~r_out_vld | i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= RW'(64'd4096);
            r_col[1] <= RW'(64'd4294967296);
            r_col[2] <= RW'(64'd4503599627370496);
            r_trans  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COL_X: r_col[0] <= i_cfg_data;
                REG_COL_Y: r_col[1] <= i_cfg_data;
                REG_COL_Z: r_col[2] <= i_cfg_data;
                REG_TRANS: r_trans  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Squared column lengths, two register stages behind the configuration.
    always_ff @(posedge i_clk) begin
        logic signed [QW-1:0]   c;
        logic signed [2*QW-1:0] sq;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                c          = signed'(r_col[j][QW*i +: QW]);
                sq         = c * c;
                r_sq[j][i] <= sq[2*QW-2:0];
            end
            r_len[j] <= LW'(r_sq[j][0]) + LW'(r_sq[j][1]) + LW'(r_sq[j][2]);
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Front stages: capture, products, then position sums and dividends.
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] acc;
        logic [PW-1:0]        mag;
        if (en) begin
            r_f0  <= i_func;
            r_l0  <= i_in_last;
            r_in[0] <= i_in_x;
            r_in[1] <= i_in_y;
            r_in[2] <= i_in_z;

            r_f1 <= r_f0;
            r_l1 <= r_l0;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_p[j][i] <= signed'(r_col[j][QW*i +: QW]) * r_in[j];
                end
            end

            r_f2 <= r_f1;
            r_l2 <= r_l1;
            for (int i = 0; i < 3; i++) begin
                acc = SW'(r_p[0][i]) + SW'(r_p[1][i]) + SW'(r_p[2][i])
                    + (SW'(signed'(r_trans[QW*i +: QW])) <<< 12);
                r_pos[i] <= acc;
                for (int j = 0; j < 3; j++) begin
                    mag = r_p[j][i][PW-1] ? PW'(-r_p[j][i]) : PW'(r_p[j][i]);
                    r_neg[3*j+i] <= r_p[j][i][PW-1];
                    r_num[3*j+i] <= NW'({mag, 12'b0}) + NW'(r_len[j] >> 1);
                end
            end
        end
    end

    always_comb begin
        s2_side.vld  = r_v2;
        s2_side.func = r_f2;
        s2_side.last = r_l2;
        s2_side.pos  = r_pos;
        s2_side.neg  = r_neg;
        for (int j = 0; j < 3; j++) begin
            s2_side.zero[j] = (r_len[j] == '0);
        end
    end

    // Nine divider lanes, one per matrix entry.
    for (genvar k = 0; k < 9; k++) begin : g_div
        avnt_div_pipe u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[k]),
            .i_den  (r_len[k/3]),
            .o_quot (quot[k])
        );
    end

    // Side data runs beside the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_side[s].vld <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= s2_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Output stage: rounding, term sums and saturation.
    always_ff @(posedge i_clk) begin
        t_side                 sd;
        logic signed [QTW+3:0] sum;
        logic signed [QTW+1:0] term;
        logic [SW-1:0]         pmag;
        logic [SW-1:0]         prnd;
        logic signed [QTW+3:0] val;
        logic                  fl;
        sd = r_side[DIV_STAGES-1];
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= sd.vld;
        end
        if (en) begin
            fl = (sd.func == FUNC_DIRECTION) && (sd.zero != 3'b000);
            for (int i = 0; i < 3; i++) begin
                sum = '0;
                for (int j = 0; j < 3; j++) begin
                    term = signed'({2'b00, quot[3*j+i]});
                    if (sd.zero[j]) begin
                        term = '0;
                    end else if (sd.neg[3*j+i]) begin
                        term = -term;
                    end
                    sum = sum + (QTW+4)'(term);
                end
                pmag = sd.pos[i][SW-1] ? SW'(-signed'(sd.pos[i])) : sd.pos[i];
                prnd = (pmag + SW'(2048)) >> 12;
                if (sd.func == FUNC_POSITION) begin
                    val = sd.pos[i][SW-1] ? -signed'((QTW+4)'(prnd)) : signed'((QTW+4)'(prnd));
                end else begin
                    val = sum;
                end
                if (val > signed'((QTW+4)'(524287))) begin
                    r_out[i] <= 20'sd524287;
                    fl = 1'b1;
                end else if (val < -signed'((QTW+4)'(524288))) begin
                    r_out[i] <= -20'sd524288;
                    fl = 1'b1;
                end else begin
                    r_out[i] <= val[QW-1:0];
                end
            end
            r_flag <= fl;
            r_last <= sd.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_flag      = r_flag;
    assign o_out_last  = r_last;

endmodule
